// File: design/three_level_priority_queue_unit_macros.svh
// Assertion macros for the three-level priority queue checker.
// No dependencies; included by the checker file only.
`ifndef THREE_LEVEL_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TLPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TLPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/tlpq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and control structs of the priority queue.
// No dependencies; used by every module of the block.
package tlpq_pkg;

  localparam int CAPACITY = 16;
  localparam int LEVELS   = 3;
  localparam int LVL_W    = 2;
  localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(LEVELS * CAPACITY);
  localparam int DATA_W   = 32;

  typedef logic [2:0] op_t;
  localparam op_t OP_INSERT     = 3'd0;
  localparam op_t OP_DEQUEUE    = 3'd1;
  localparam op_t OP_PEEK_FRONT = 3'd2;
  localparam op_t OP_PEEK_BACK  = 3'd3;
  localparam op_t OP_LIST_FWD   = 3'd4;
  localparam op_t OP_LIST_REV   = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_EMPTY  = 2'd1;
  localparam status_t ST_FULL   = 2'd2;
  localparam status_t ST_BADPRI = 2'd3;

  localparam logic [1:0] PRI_INVALID = 2'd3;

  typedef enum logic [1:0] {
    RD_FRONT,
    RD_BACK,
    RD_CURSOR
  } rd_src_t;

  typedef struct packed {
    logic    load;
    logic    emit;
    status_t emit_status;
    logic    emit_last;
    logic    emit_mem;
    rd_src_t rd_src;
    logic    do_write;
    logic    do_dequeue;
    logic    list_init;
    logic    list_step;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic pri_bad;
    logic full;
    logic empty;
    logic list_final;
  } stat_t;

endpackage

// File: design/tlpq_datapath.sv
`timescale 1ns / 1ps
// Datapath: entry memory, per-level pointers and counts, listing cursor
// and the registered result outputs. Depends on tlpq_pkg.
module tlpq_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  tlpq_pkg::cmd_t                    cmd,
  output tlpq_pkg::stat_t                   stat,
  input  logic [2:0]                        operation,
  input  logic signed [tlpq_pkg::DATA_W-1:0] item_value,
  input  logic [1:0]                        priority_req,
  output logic signed [tlpq_pkg::DATA_W-1:0] result_value,
  output logic [1:0]                        status,
  output logic                              last,
  output logic                              strobe
);

  function automatic logic [tlpq_pkg::PTR_W-1:0] ptr_inc(
    input logic [tlpq_pkg::PTR_W-1:0] p
  );
    return (p == tlpq_pkg::PTR_W'(tlpq_pkg::CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [tlpq_pkg::PTR_W-1:0] ptr_dec(
    input logic [tlpq_pkg::PTR_W-1:0] p
  );
    return (p == '0) ? tlpq_pkg::PTR_W'(tlpq_pkg::CAPACITY - 1) : p - 1'b1;
  endfunction

  function automatic logic [tlpq_pkg::ADDR_W-1:0] mem_addr(
    input logic [tlpq_pkg::LVL_W-1:0] lv,
    input logic [tlpq_pkg::PTR_W-1:0] s
  );
    return tlpq_pkg::ADDR_W'(lv) * tlpq_pkg::ADDR_W'(tlpq_pkg::CAPACITY)
           + tlpq_pkg::ADDR_W'(s);
  endfunction

  logic [tlpq_pkg::DATA_W-1:0] mem [tlpq_pkg::LEVELS*tlpq_pkg::CAPACITY];
  logic [tlpq_pkg::DATA_W-1:0] rdata;

  tlpq_pkg::op_t               op_q;
  logic [tlpq_pkg::DATA_W-1:0] val_q;
  logic [1:0]                  pri_q;

  logic [tlpq_pkg::PTR_W-1:0] rp  [tlpq_pkg::LEVELS];
  logic [tlpq_pkg::PTR_W-1:0] wp  [tlpq_pkg::LEVELS];
  logic [tlpq_pkg::CNT_W-1:0] cnt [tlpq_pkg::LEVELS];

  logic [tlpq_pkg::LVL_W-1:0] lvl_c;
  logic [tlpq_pkg::PTR_W-1:0] slot_c;
  logic [tlpq_pkg::CNT_W-1:0] lvl_rem;
  logic [tlpq_pkg::CNT_W-1:0] tot_rem;

  logic from_mem;

  logic [tlpq_pkg::CNT_W-1:0] total;
  logic [tlpq_pkg::LVL_W-1:0] lv_front;
  logic [tlpq_pkg::LVL_W-1:0] lv_back;
  logic [tlpq_pkg::LVL_W-1:0] lv_next;
  logic                       fwd;
  logic [tlpq_pkg::ADDR_W-1:0] rd_addr;

  always_comb begin
    total    = cnt[0] + cnt[1] + cnt[2];
    lv_front = (cnt[2] != '0) ? 2'd2 : ((cnt[1] != '0) ? 2'd1 : 2'd0);
    lv_back  = (cnt[0] != '0) ? 2'd0 : ((cnt[1] != '0) ? 2'd1 : 2'd2);
    fwd      = (op_q == tlpq_pkg::OP_LIST_FWD);
    // next non-empty level in listing order; the remaining count guarantees one
    if (fwd) begin
      lv_next = (lvl_c == 2'd2 && cnt[1] != '0) ? 2'd1 : 2'd0;
    end else begin
      lv_next = (lvl_c == 2'd0 && cnt[1] != '0) ? 2'd1 : 2'd2;
    end
    case (cmd.rd_src)
      tlpq_pkg::RD_FRONT: rd_addr = mem_addr(lv_front, rp[lv_front]);
      tlpq_pkg::RD_BACK:  rd_addr = mem_addr(lv_back, ptr_dec(wp[lv_back]));
      default:            rd_addr = mem_addr(lvl_c, slot_c);
    endcase
  end

  assign stat.op         = op_q;
  assign stat.pri_bad    = (pri_q == tlpq_pkg::PRI_INVALID);
  assign stat.full       = (total >= tlpq_pkg::CNT_W'(tlpq_pkg::CAPACITY));
  assign stat.empty      = (total == '0);
  assign stat.list_final = (tot_rem == tlpq_pkg::CNT_W'(1));

  // memory: one write for inserts, one registered read for emitted entries
  always_ff @(posedge clk) begin
    if (cmd.do_write) begin
      mem[mem_addr(pri_q, wp[pri_q])] <= val_q;
    end
    if (cmd.emit && cmd.emit_mem) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      val_q <= item_value;
      pri_q <= priority_req;
    end
    if (cmd.list_init) begin
      tot_rem <= total;
      if (fwd) begin
        lvl_c   <= lv_front;
        slot_c  <= rp[lv_front];
        lvl_rem <= cnt[lv_front];
      end else begin
        lvl_c   <= lv_back;
        slot_c  <= ptr_dec(wp[lv_back]);
        lvl_rem <= cnt[lv_back];
      end
    end else if (cmd.list_step) begin
      tot_rem <= tot_rem - 1'b1;
      if (lvl_rem == tlpq_pkg::CNT_W'(1)) begin
        lvl_c   <= lv_next;
        slot_c  <= fwd ? rp[lv_next] : ptr_dec(wp[lv_next]);
        lvl_rem <= cnt[lv_next];
      end else begin
        slot_c  <= fwd ? ptr_inc(slot_c) : ptr_dec(slot_c);
        lvl_rem <= lvl_rem - 1'b1;
      end
    end
    if (cmd.emit) begin
      status   <= cmd.emit_status;
      last     <= cmd.emit_last;
      from_mem <= cmd.emit_mem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      for (int i = 0; i < tlpq_pkg::LEVELS; i++) begin
        rp[i]  <= '0;
        wp[i]  <= '0;
        cnt[i] <= '0;
      end
    end else begin
      strobe <= cmd.emit;
      if (cmd.do_write) begin
        wp[pri_q]  <= ptr_inc(wp[pri_q]);
        cnt[pri_q] <= cnt[pri_q] + 1'b1;
      end
      if (cmd.do_dequeue) begin
        rp[lv_front]  <= ptr_inc(rp[lv_front]);
        cnt[lv_front] <= cnt[lv_front] - 1'b1;
      end
    end
  end

  // zero on every result that carries no stored entry
  assign result_value = from_mem ? $signed(rdata) : '0;

endmodule

// File: design/tlpq_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences one transaction at a time and issues datapath
// commands from datapath status. Depends on tlpq_pkg.
module tlpq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  tlpq_pkg::stat_t stat,
  output tlpq_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_LIST
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd         = '0;
    cmd.rd_src  = tlpq_pkg::RD_FRONT;
    state_next  = state;
    case (state)
      S_IDLE: begin
        cmd.load = start && !busy;
        if (start && !busy) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        case (stat.op)
          tlpq_pkg::OP_INSERT: begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            if (stat.pri_bad) begin
              cmd.emit_status = tlpq_pkg::ST_BADPRI;
            end else if (stat.full) begin
              cmd.emit_status = tlpq_pkg::ST_FULL;
            end else begin
              cmd.emit_status = tlpq_pkg::ST_OK;
              cmd.do_write    = 1'b1;
            end
          end
          tlpq_pkg::OP_DEQUEUE, tlpq_pkg::OP_PEEK_FRONT, tlpq_pkg::OP_PEEK_BACK: begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            if (stat.empty) begin
              cmd.emit_status = tlpq_pkg::ST_EMPTY;
            end else begin
              cmd.emit_status = tlpq_pkg::ST_OK;
              cmd.emit_mem    = 1'b1;
              cmd.rd_src      = (stat.op == tlpq_pkg::OP_PEEK_BACK) ?
                                tlpq_pkg::RD_BACK : tlpq_pkg::RD_FRONT;
              cmd.do_dequeue  = (stat.op == tlpq_pkg::OP_DEQUEUE);
            end
          end
          tlpq_pkg::OP_LIST_FWD, tlpq_pkg::OP_LIST_REV: begin
            if (stat.empty) begin
              cmd.emit        = 1'b1;
              cmd.emit_last   = 1'b1;
              cmd.emit_status = tlpq_pkg::ST_EMPTY;
            end else begin
              cmd.list_init = 1'b1;
              state_next    = S_LIST;
            end
          end
          default: begin
            // undefined codes: drop with no result
            state_next = S_IDLE;
          end
        endcase
      end
      S_LIST: begin
        cmd.emit        = 1'b1;
        cmd.emit_status = tlpq_pkg::ST_OK;
        cmd.emit_mem    = 1'b1;
        cmd.emit_last   = stat.list_final;
        cmd.rd_src      = tlpq_pkg::RD_CURSOR;
        cmd.list_step   = 1'b1;
        if (stat.list_final) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

// File: design/three_level_priority_queue_unit.sv
`timescale 1ns / 1ps
// Three-level strict priority queue. The result strobes in the cycle after
// the decode cycle for insert, dequeue, peeks and empty listings. Listings
// emit one result per stored entry, with one memory read per entry.
// Results cannot be stalled. Synchronous active-high reset empties all levels;
// entry memory is not cleared and needs no clearing pass.
module three_level_priority_queue_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         operation,
  input  logic signed [tlpq_pkg::DATA_W-1:0] item_value,
  input  logic [1:0]                         priority_req,
  output logic signed [tlpq_pkg::DATA_W-1:0] result_value,
  output logic [1:0]                         status,
  output logic                               last,
  output logic                               strobe
);

  tlpq_pkg::cmd_t  cmd;
  tlpq_pkg::stat_t stat;

  tlpq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  tlpq_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (operation),
    .item_value   (item_value),
    .priority_req (priority_req),
    .result_value (result_value),
    .status       (status),
    .last         (last),
    .strobe       (strobe)
  );

endmodule

// File: design/tlpq_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the priority queue top level, bound below.
// Depends on tlpq_pkg and three_level_priority_queue_unit_macros.svh.
`include "three_level_priority_queue_unit_macros.svh"

module tlpq_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic signed [tlpq_pkg::DATA_W-1:0] result_value,
  input logic [1:0]                         status,
  input logic                               last,
  input logic                               strobe
);

  `TLPQ_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted transaction did not raise busy")
  `TLPQ_ASSERT_NOW(a_err_last, clk, rst, strobe && status != tlpq_pkg::ST_OK, last, "error result without last")
  `TLPQ_ASSERT_NOW(a_err_zero, clk, rst, strobe && status != tlpq_pkg::ST_OK, result_value == '0, "error result with nonzero value")
  `TLPQ_ASSERT_NEXT(a_list_cont, clk, rst, strobe && !last, strobe, "listing broke off before last")

endmodule

bind three_level_priority_queue_unit tlpq_checker u_tlpq_checker (.*);
